@@ src/pss_pkg.sv @@
package pss_pkg;

   localparam int MAX_TABLE_ENTRIES_DEF = 65536;
   localparam int SYMBOL_COUNT_DEF = 256;
   localparam logic [4:0] TABLE_LOG_RESET = 5'd12;

   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef struct packed {
      logic load_add;
      logic load_read;
      logic step;
      logic finish;
      logic load_rsp;
   } pss_cmd_type;

   typedef struct packed {
      logic sym_ok;
      logic run_zero;
      logic last;
   } pss_status_type;

   function automatic logic [4:0] eff_log(input logic [4:0] tl, input int max_log);
      logic [4:0] lg;
      lg = tl;
      if (lg < 5'd1) begin
         lg = 5'd1;
      end
      if (lg > 5'(max_log)) begin
         lg = 5'(max_log);
      end
      return lg;
   endfunction

   function automatic logic [15:0] step_prime(input logic [4:0] lg);
      logic [15:0] p;
      case (lg) inside
         [5'd0:5'd4]: p = 16'd3;
         5'd5, 5'd6:  p = 16'd23;
         5'd7:        p = 16'd47;
         5'd8:        p = 16'd181;
         5'd9:        p = 16'd881;
         5'd10:       p = 16'd8053;
         5'd11:       p = 16'd883;
         5'd12:       p = 16'd1607;
         5'd13:       p = 16'd18149;
         5'd14:       p = 16'd11807;
         5'd15:       p = 16'd1399;
         default:     p = 16'd29333;
      endcase
      return p;
   endfunction

endpackage

@@ src/prime_step_symbol_spread.sv @@
// Read: a read transaction loads its entry into a data register and then, once the
// response slot is free, into the response register. req_stall holds off new requests
// until the current one is done; an add writes min(run_count, size) table entries, one
// per cycle via the single write port; an add with an out-of-range symbol writes none.
// Reset: write position cleared, table_log back to 12; table contents are not cleared.
module prime_step_symbol_spread #(
   parameter int MAX_TABLE_ENTRIES = pss_pkg::MAX_TABLE_ENTRIES_DEF,
   parameter int SYMBOL_COUNT = pss_pkg::SYMBOL_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [4:0]  csr_table_log,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic        req_first,
   input  logic [7:0]  req_symbol,
   input  logic [16:0] req_run_count,
   input  logic [15:0] req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_entry_symbol
);
   import pss_pkg::*;

   pss_cmd_type    cmd;
   pss_status_type status;

   pss_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pss_datapath #(
      .MAX_TABLE_ENTRIES (MAX_TABLE_ENTRIES),
      .SYMBOL_COUNT      (SYMBOL_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_table_log    (csr_table_log),
      .req_first        (req_first),
      .req_symbol       (req_symbol),
      .req_run_count    (req_run_count),
      .req_read_index   (req_read_index),
      .cmd              (cmd),
      .status           (status),
      .rsp_entry_symbol (rsp_entry_symbol)
   );

endmodule

@@ src/pss_datapath.sv @@
module pss_datapath #(
   parameter int MAX_TABLE_ENTRIES = 65536,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [4:0]             csr_table_log,
   input  logic                   req_first,
   input  logic [7:0]             req_symbol,
   input  logic [16:0]            req_run_count,
   input  logic [15:0]            req_read_index,
   input  pss_pkg::pss_cmd_type    cmd,
   output pss_pkg::pss_status_type status,
   output logic [7:0]             rsp_entry_symbol
);
   import pss_pkg::*;

   localparam int ClogMax = $clog2(MAX_TABLE_ENTRIES);
   localparam int AddrW = ((1 << ClogMax) > MAX_TABLE_ENTRIES) ? ClogMax - 1 : ClogMax;
   localparam int Depth = 1 << AddrW;
   localparam int SymW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

   logic [SymW-1:0] mem [Depth];

   logic [4:0]        cfg_log;
   logic [16:0]       cfg_size;
   logic [16:0]       size_ff, size_in;
   logic [AddrW-1:0]  mask_ff, mask_in;
   logic [AddrW-1:0]  prime_ff, prime_in;
   logic [AddrW-1:0]  wp_ff, wp_in;
   logic [AddrW-1:0]  pos_ff, pos_in;
   logic [16:0]       cnt_ff, cnt_in;
   logic [SymW-1:0]   sym_ff, sym_in;
   logic [AddrW-1:0]  prod_ff, prod_in;
   logic [2*AddrW-1:0] prod_full;
   logic [SymW-1:0]   rd_data_ff;
   logic [7:0]        rsp_sym_ff, rsp_sym_in;
   logic [AddrW-1:0]  start_pos;
   logic [AddrW-1:0]  rd_addr;

   assign cfg_log  = eff_log(reset ? TABLE_LOG_RESET : csr_table_log, AddrW);
   assign cfg_size = 17'(1) << cfg_log;
   assign size_in  = cfg_size;
   assign mask_in  = AddrW'(cfg_size - 17'd1);
   assign prime_in = AddrW'(step_prime(cfg_log));

   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         size_ff  <= size_in;
         mask_ff  <= mask_in;
         prime_ff <= prime_in;
      end
   end

   assign start_pos = req_first ? '0 : (wp_ff & mask_ff);
   assign prod_full = req_run_count[AddrW-1:0] * prime_ff;
   assign rd_addr   = req_read_index[AddrW-1:0] & mask_ff;

   assign status.sym_ok   = {1'b0, req_symbol} < 9'(SYMBOL_COUNT);
   assign status.run_zero = (req_run_count == 17'd0);
   assign status.last     = (cnt_ff == 17'd1);

   always_comb begin
      wp_in      = wp_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      sym_in     = sym_ff;
      prod_in    = prod_ff;
      rsp_sym_in = rsp_sym_ff;
      if (cmd.load_add) begin
         wp_in   = req_first ? '0 : wp_ff;
         pos_in  = start_pos;
         cnt_in  = (req_run_count > size_ff) ? size_ff : req_run_count;
         sym_in  = req_symbol[SymW-1:0];
         prod_in = prod_full[AddrW-1:0];
      end
      if (cmd.step) begin
         pos_in = (pos_ff + prime_ff) & mask_ff;
         cnt_in = cnt_ff - 17'd1;
      end
      if (cmd.finish) begin
         wp_in = (wp_ff + prod_ff) & mask_ff;
      end
      if (cmd.load_rsp) begin
         rsp_sym_in = 8'(rd_data_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      cnt_ff     <= cnt_in;
      sym_ff     <= sym_in;
      prod_ff    <= prod_in;
      rsp_sym_ff <= rsp_sym_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         mem[pos_ff] <= sym_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_entry_symbol = rsp_sym_ff;

   a_step_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> cnt_ff != 17'd0)
      else $error("write step with exhausted count");

   a_step_pos_in_table: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (pos_ff & ~mask_ff) == '0)
      else $error("write position outside table");

endmodule

@@ src/pss_control.sv @@
module pss_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_mode,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  pss_pkg::pss_status_type status,
   output pss_pkg::pss_cmd_type    cmd
);
   import pss_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WRITE  = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;
   localparam logic [1:0] S_READ   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_READ) begin
                  cmd.load_read = 1'b1;
                  state_in      = S_READ;
               end else begin
                  cmd.load_add = 1'b1;
                  if (status.sym_ok) begin
                     state_in = status.run_zero ? S_FINISH : S_WRITE;
                  end
               end
            end
         end
         S_WRITE: begin
            cmd.step = 1'b1;
            if (status.last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         S_READ: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_add, cmd.load_read, cmd.step, cmd.finish, cmd.load_rsp}))
      else $error("more than one datapath command");

   a_write_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) && !status.last |=> state_ff == S_WRITE)
      else $error("write run left early");

   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      accept && (req_mode == MODE_READ) |=> state_ff == S_READ)
      else $error("read transaction not tracked");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !cmd.load_rsp)
      else $error("pending response overwritten");

endmodule
